/* src/ffsga_pkg.sv */
`timescale 1ns / 1ps

package ffsga_pkg;

	// Default grid and square limits
	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_MAX_SIDE    = 8;

	// Fixed field widths
	localparam int SIDE_W  = 4;
	localparam int CFG_W   = 7;
	localparam int COORD_W = 6;
	localparam int CNT_W   = 4;
	// Width for row and column arithmetic that must not wrap
	localparam int IDX_W   = 9;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'b1;

	// Register values after reset
	localparam logic [CFG_W-1:0] COLS_RESET = 7'd38;
	localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;

	// Controller to datapath commands
	typedef struct packed {
		logic take_in;
		logic init;
		logic scan;
		logic set_zero;
		logic set_miss;
		logic set_hit;
		logic mark_rd;
		logic mark_wr;
		logic load_out;
	} ffsga_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic side_zero;
		logic side_bad;
		logic hit;
		logic miss;
		logic mark_last;
	} ffsga_sts_t;

endpackage

/* src/first_fit_square_grid_allocator.sv */
`timescale 1ns / 1ps

// First-fit allocator of square regions on a grid of cells.
// Input channel (in_valid/in_ready, square_side): one beat is one request.
// Output channel (out_valid/out_ready, found, origin_column, origin_row):
// one beat per request, in request order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets
// grid_columns, index 1 sets grid_rows; always ready, write only while idle.
// A zero or oversize side passes from the check state straight to the done state.
// Otherwise the scan streams one grid row per cycle through the single read
// port of the occupancy memory, then marks the square by read-modify-write,
// a read state and a write state per row. One request is in work at a time.
// A finished result sits in the output register; the next request is taken
// while it waits, and its result is held until the receiver drains the
// register, so a stalled receiver stalls the block, never drops a beat.
// Reset: all cells free through per-row valid bits (no clearing pass),
// grid_columns = 38, grid_rows = 64.
module first_fit_square_grid_allocator #(
	parameter int MAX_COLUMNS = ffsga_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = ffsga_pkg::DEF_MAX_ROWS,
	parameter int MAX_SIDE    = ffsga_pkg::DEF_MAX_SIDE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ffsga_pkg::SIDE_W-1:0]     square_side,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [ffsga_pkg::COORD_W-1:0]    origin_column,
	output logic [ffsga_pkg::COORD_W-1:0]    origin_row,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ffsga_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffsga_pkg::CFG_W-1:0]      cfg_data
);

	ffsga_pkg::ffsga_cmd_t cmd;
	ffsga_pkg::ffsga_sts_t sts;
	logic                  cfg_we;

	// Registers take a write on any cycle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	ffsga_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffsga_dp #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.MAX_SIDE    (MAX_SIDE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.square_side   (square_side),
		.found         (found),
		.origin_column (origin_column),
		.origin_row    (origin_row)
	);

`ifndef SYNTH
	// A taken request closes the input until its result is formed
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	// A miss carries zero coordinates
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> origin_column == '0 && origin_row == '0)
		else $error("not-found result with nonzero origin");

	// Every marking write follows the read of the same row
	a_mark_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_wr |-> $past(cmd.mark_rd))
		else $error("marking write without preceding read");
`endif

endmodule

/* src/ffsga_ctrl.sv */
`timescale 1ns / 1ps

module ffsga_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  ffsga_pkg::ffsga_sts_t sts,
	output ffsga_pkg::ffsga_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CHECK   = 3'd1;
	localparam logic [2:0] ST_SCAN    = 3'd2;
	localparam logic [2:0] ST_MARK_RD = 3'd3;
	localparam logic [2:0] ST_MARK_WR = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Sequence one request: check, scan if the side fits, mark on a hit, hand off
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.init = 1'b1;
				if (sts.side_zero) begin
					cmd.set_zero = 1'b1;
					state_d      = ST_DONE;
				end else if (sts.side_bad) begin
					cmd.set_miss = 1'b1;
					state_d      = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.set_hit = 1'b1;
					state_d     = ST_MARK_RD;
				end else if (sts.miss) begin
					cmd.set_miss = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_MARK_RD: begin
				cmd.mark_rd = 1'b1;
				state_d     = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				state_d     = sts.mark_last ? ST_DONE : ST_MARK_RD;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* src/ffsga_dp.sv */
`timescale 1ns / 1ps

module ffsga_dp #(
	parameter int MAX_COLUMNS = ffsga_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = ffsga_pkg::DEF_MAX_ROWS,
	parameter int MAX_SIDE    = ffsga_pkg::DEF_MAX_SIDE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ffsga_pkg::ffsga_cmd_t             cmd,
	output ffsga_pkg::ffsga_sts_t             sts,
	input  logic                              cfg_we,
	input  logic [ffsga_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffsga_pkg::CFG_W-1:0]       cfg_data,
	input  logic [ffsga_pkg::SIDE_W-1:0]      square_side,
	output logic                              found,
	output logic [ffsga_pkg::COORD_W-1:0]     origin_column,
	output logic [ffsga_pkg::COORD_W-1:0]     origin_row
);

	localparam int IW = ffsga_pkg::IDX_W;
	localparam int SW = ffsga_pkg::SIDE_W;
	localparam int NW = ffsga_pkg::CNT_W;
	localparam int KW = ffsga_pkg::CFG_W;
	localparam int OW = ffsga_pkg::COORD_W;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	// Request and configuration
	logic [SW-1:0] side_q;
	logic [KW-1:0] cols_q;
	logic [KW-1:0] rows_q;
	logic [KW-1:0] cols_eff;
	logic [KW-1:0] rows_eff;

	// Occupancy memory, one word per row
	logic [MAX_COLUMNS-1:0] mem_q [MAX_ROWS];
	logic [MAX_ROWS-1:0]    row_vld_q;
	logic [MAX_COLUMNS-1:0] rd_data_q;
	logic                   rd_vld_q;
	logic [MAX_COLUMNS-1:0] row_eff;
	logic                   rd_en;
	logic [RW-1:0]          rd_addr;
	logic [MAX_COLUMNS-1:0] wr_data;

	// Scan pipeline
	logic [RW-1:0]          scan_row_q;
	logic                   issuing_q;
	logic                   scan_issue;
	logic                   scan_last;
	logic                   v_s1;
	logic [RW-1:0]          tag_s1;
	logic                   v_s2;
	logic [RW-1:0]          tag_s2;
	logic [MAX_COLUMNS-1:0] hit_s2;
	logic [NW-1:0]          cnt_q [MAX_COLUMNS];
	logic [NW-1:0]          cnt_d [MAX_COLUMNS];
	logic [MAX_COLUMNS-1:0] win_free;
	logic [MAX_COLUMNS-1:0] hit_d;
	logic                   hit_any;
	logic [CW-1:0]          hit_col;
	logic [IW-1:0]          hit_row;

	// Marking
	logic [CW-1:0]          orig_col_q;
	logic [RW-1:0]          mark_row_q;
	logic [SW-1:0]          mark_left_q;
	logic [MAX_COLUMNS-1:0] mark_mask;

	// Pending result
	logic          pend_found_q;
	logic [OW-1:0] pend_col_q;
	logic [OW-1:0] pend_row_q;

	// Clamp registers to the grid size
	assign cols_eff = (IW'(cols_q) > IW'(MAX_COLUMNS)) ? KW'(MAX_COLUMNS) : cols_q;
	assign rows_eff = (IW'(rows_q) > IW'(MAX_ROWS)) ? KW'(MAX_ROWS) : rows_q;

	// Capture the requested side
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			side_q <= square_side;
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= ffsga_pkg::COLS_RESET;
			rows_q <= ffsga_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ffsga_pkg::REG_GRID_COLUMNS: cols_q <= cfg_data;
				ffsga_pkg::REG_GRID_ROWS:    rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Trivial outcomes
	assign sts.side_zero = (side_q == '0);
	assign sts.side_bad  = (IW'(side_q) > IW'(MAX_SIDE)) || (IW'(side_q) > IW'(cols_eff))
		|| (IW'(side_q) > IW'(rows_eff));

	// Memory port selection
	assign scan_issue = cmd.scan && issuing_q;
	assign scan_last  = (IW'(scan_row_q) == IW'(rows_eff) - IW'(1));
	assign rd_en      = scan_issue || cmd.mark_rd;
	assign rd_addr    = cmd.mark_rd ? mark_row_q : scan_row_q;
	assign row_eff    = rd_vld_q ? rd_data_q : '0;
	assign wr_data    = row_eff | mark_mask;

	// Memory read and write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_vld_q  <= row_vld_q[rd_addr];
		end
		if (cmd.mark_wr) begin
			mem_q[mark_row_q] <= wr_data;
		end
	end

	// Row valid bits: a row never written reads as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (cmd.mark_wr) begin
			row_vld_q[mark_row_q] <= 1'b1;
		end
	end

	// Walk the scan address over the rows in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			issuing_q  <= 1'b0;
		end else if (cmd.init) begin
			scan_row_q <= '0;
			issuing_q  <= 1'b1;
		end else if (scan_issue) begin
			if (scan_last) begin
				issuing_q <= 1'b0;
			end else begin
				scan_row_q <= scan_row_q + RW'(1);
			end
		end
	end

	// Window test per column and run of fitting rows ending here
	always_comb begin
		logic busy;
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			busy = 1'b0;
			for (int k = 0; k < MAX_SIDE; k++) begin
				if (c + k < MAX_COLUMNS) begin
					if (SW'(k) < side_q) begin
						busy = busy | row_eff[c + k];
					end
				end
			end
			win_free[c] = !busy && ((IW'(c) + IW'(side_q)) <= IW'(cols_eff));
			hit_d[c]    = win_free[c] && ((IW'(cnt_q[c]) + IW'(1)) >= IW'(side_q));
			if (!win_free[c]) begin
				cnt_d[c] = '0;
			end else if (&cnt_q[c]) begin
				cnt_d[c] = cnt_q[c];
			end else begin
				cnt_d[c] = cnt_q[c] + NW'(1);
			end
		end
	end

	// Stage valids and row tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (cmd.init) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= scan_issue;
			v_s2 <= v_s1 && cmd.scan;
		end
	end

	// Per-column run counters and registered hit vector
	always_ff @(posedge clk) begin
		tag_s1 <= scan_row_q;
		if (cmd.init) begin
			for (int c = 0; c < MAX_COLUMNS; c++) begin
				cnt_q[c] <= '0;
			end
		end else if (v_s1 && cmd.scan) begin
			for (int c = 0; c < MAX_COLUMNS; c++) begin
				cnt_q[c] <= cnt_d[c];
			end
			hit_s2 <= hit_d;
			tag_s2 <= tag_s1;
		end
	end

	// Pick the lowest hitting column
	always_comb begin
		hit_any = |hit_s2;
		hit_col = '0;
		for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
			if (hit_s2[c]) begin
				hit_col = CW'(c);
			end
		end
	end

	assign hit_row  = IW'(tag_s2) - IW'(side_q) + IW'(1);
	assign sts.hit  = v_s2 && hit_any;
	assign sts.miss = v_s2 && !hit_any && (IW'(tag_s2) == IW'(rows_eff) - IW'(1));

	// Columns covered by the allocated square
	always_comb begin
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			mark_mask[c] = (IW'(c) >= IW'(orig_col_q))
				&& (IW'(c) < IW'(orig_col_q) + IW'(side_q));
		end
	end

	// Track rows left to mark
	always_ff @(posedge clk) begin
		if (cmd.set_hit) begin
			orig_col_q  <= hit_col;
			mark_row_q  <= hit_row[RW-1:0];
			mark_left_q <= side_q;
		end else if (cmd.mark_wr) begin
			mark_row_q  <= mark_row_q + RW'(1);
			mark_left_q <= mark_left_q - SW'(1);
		end
	end

	assign sts.mark_last = (mark_left_q == SW'(1));

	// Pending result
	always_ff @(posedge clk) begin
		if (cmd.set_zero) begin
			pend_found_q <= 1'b1;
			pend_col_q   <= '0;
			pend_row_q   <= '0;
		end else if (cmd.set_miss) begin
			pend_found_q <= 1'b0;
			pend_col_q   <= '0;
			pend_row_q   <= '0;
		end else if (cmd.set_hit) begin
			pend_found_q <= 1'b1;
			pend_col_q   <= OW'(hit_col);
			pend_row_q   <= hit_row[OW-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found         <= pend_found_q;
			origin_column <= pend_col_q;
			origin_row    <= pend_row_q;
		end
	end

endmodule

/* sim/tb_first_fit_square_grid_allocator.sv */
`timescale 1ns / 1ps

module tb_first_fit_square_grid_allocator;
	import ffsga_pkg::*;

	localparam int GRID_COLS_MAX = DEF_MAX_COLUMNS;
	localparam int GRID_ROWS_MAX = DEF_MAX_ROWS;
	localparam int SIDE_MAX      = DEF_MAX_SIDE;
	localparam int QUIET_LIMIT   = 4000;
	localparam int IDLE_PCT      = 22;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] origin_column;
		logic [COORD_W-1:0] origin_row;
	} grant_t;

	// Track the occupancy map and the grants it implies, in request order
	class grant_scoreboard;
		bit [GRID_COLS_MAX-1:0] used_cells[GRID_ROWS_MAX];
		logic [CFG_W-1:0]       grid_cols;
		logic [CFG_W-1:0]       grid_rows;
		grant_t                 expected_grants[$];
		int                     errors;

		function new();
			foreach (used_cells[r])
				used_cells[r] = '0;
			grid_cols = COLS_RESET;
			grid_rows = ROWS_RESET;
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_GRID_COLUMNS)
				grid_cols = data;
			else if (idx == REG_GRID_ROWS)
				grid_rows = data;
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction

		// Scan origins row by row, first free fit wins, then mark its cells
		function void note_request(logic [SIDE_W-1:0] side);
			grant_t                 g;
			int                     cols;
			int                     rows;
			int                     n;
			bit [GRID_COLS_MAX-1:0] span;
			bit                     clear;
			bit                     done;
			g = '0;
			n = side;
			cols = (grid_cols > GRID_COLS_MAX) ? GRID_COLS_MAX : grid_cols;
			rows = (grid_rows > GRID_ROWS_MAX) ? GRID_ROWS_MAX : grid_rows;
			if (n == 0) begin
				g.found = 1'b1;
			end else if (n <= SIDE_MAX && n <= cols && n <= rows) begin
				span = (64'd1 << n) - 64'd1;
				done = 1'b0;
				for (int r = 0; r + n <= rows && !done; r++) begin
					for (int c = 0; c + n <= cols && !done; c++) begin
						clear = 1'b1;
						for (int k = 0; k < n; k++)
							if ((used_cells[r + k] & (span << c)) != '0)
								clear = 1'b0;
						if (clear) begin
							for (int k = 0; k < n; k++)
								used_cells[r + k] |= span << c;
							g.found         = 1'b1;
							g.origin_column = c[COORD_W-1:0];
							g.origin_row    = r[COORD_W-1:0];
							done            = 1'b1;
						end
					end
				end
			end
			expected_grants.push_back(g);
		endfunction

		// Compare one result beat against the oldest expected grant
		function void check_grant(logic f, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
			grant_t g;
			if (expected_grants.size() == 0) begin
				$error("result beat with no request waiting: found=%0d column=%0d row=%0d",
					f, col, row);
				errors++;
				return;
			end
			g = expected_grants.pop_front();
			if (f !== g.found) begin
				$error("found: expected %0d, got %0d", g.found, f);
				errors++;
			end
			if (col !== g.origin_column) begin
				$error("origin_column: expected %0d, got %0d", g.origin_column, col);
				errors++;
			end
			if (row !== g.origin_row) begin
				$error("origin_row: expected %0d, got %0d", g.origin_row, row);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [SIDE_W-1:0]    square_side;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 found;
	logic [COORD_W-1:0]   origin_column;
	logic [COORD_W-1:0]   origin_row;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bit                   calm = 1'b0;
	int                   quiet_cycles = 0;
	grant_scoreboard      sb = new();

	first_fit_square_grid_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.square_side   (square_side),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.origin_column (origin_column),
		.origin_row    (origin_row),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Stall the result side at random, except during the calm stretch
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Record every beat at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_grant(found, origin_column, origin_row);
			if (in_valid && in_ready)
				sb.note_request(square_side);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// End the run when no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Mostly small squares, some large, a few zero and oversize
	function automatic logic [SIDE_W-1:0] pick_side();
		int roll;
		roll = $urandom_range(99);
		if (roll < 4)
			return '0;
		else if (roll < 8)
			return SIDE_W'($urandom_range(15, SIDE_MAX + 1));
		else if (roll < 70)
			return SIDE_W'($urandom_range(2, 1));
		else if (roll < 90)
			return SIDE_W'($urandom_range(4, 3));
		else
			return SIDE_W'($urandom_range(SIDE_MAX, 5));
	endfunction

	// Present one request beat; leave valid high on return
	task automatic send_request(input logic [SIDE_W-1:0] side);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		square_side <= side;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold requests until every expected grant has come back
	task automatic drain_requests();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Write both grid registers back to back, then drop valid
	task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
		cfg_valid <= 1'b1;
		cfg_index <= REG_GRID_COLUMNS;
		cfg_data  <= cols;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_index <= REG_GRID_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random requests under one grid setting
	task automatic run_phase(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
		input int count, input int calm_from, input int calm_to, input int pause_at);
		drain_requests();
		set_grid(cols, rows);
		for (int i = 0; i < count; i++) begin
			calm = (i >= calm_from) && (i < calm_to);
			if (i == pause_at)
				drain_requests();
			send_request(pick_side());
		end
		calm = 1'b0;
	endtask

	initial begin
		byte unsigned reset_sides[13] = '{0, 1, 8, 9, 15, 2, 3, 4, 5, 6, 7, 8, 8};

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		square_side = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_GRID_COLUMNS;
		cfg_data    = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset grid: zero, unit, largest, oversize and every size between
		foreach (reset_sides[i])
			send_request(SIDE_W'(reset_sides[i]));

		// No columns, then no rows: only a zero side succeeds
		drain_requests();
		set_grid('0, 7'd64);
		send_request(4'd1);
		send_request(4'd0);
		drain_requests();
		set_grid(7'd64, '0);
		send_request(4'd3);
		send_request(4'd0);

		// Single cell already taken at the corner
		drain_requests();
		set_grid(7'd1, 7'd1);
		send_request(4'd1);
		send_request(4'd1);

		// Side wider than the grid, then one that just fits
		drain_requests();
		set_grid(7'd5, 7'd127);
		send_request(4'd6);
		send_request(4'd5);

		// Full grid, largest square
		drain_requests();
		set_grid(7'd64, 7'd64);
		send_request(4'd8);

		// Random phases; saturated registers first, then narrower and wider grids
		run_phase(7'd127, 7'd127, 250, -1, -1, -1);
		run_phase(7'd20, 7'd40, 200, -1, -1, 100);
		run_phase(7'd64, 7'd64, 280, 60, 200, -1);
		run_phase(7'd1, 7'd64, 60, -1, -1, -1);
		run_phase(7'd64, 7'd1, 60, -1, -1, -1);
		run_phase(7'd40, 7'd127, 280, -1, -1, 140);

		drain_requests();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
